FILE: src/rqfi_pkg.sv
// ----------------------------------------------------------------------------
// rqfi_pkg
// types, codes and default sizes for the ring queue with front insert
// ----------------------------------------------------------------------------
package rqfi_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int VALUE_BITS_DEF = 8;

	localparam int CMD_W  = 2;
	localparam int VAL_W  = 8;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND   = 2'd0,
		CMD_PRIORITY = 2'd1,
		CMD_REMOVE   = 2'd2,
		CMD_PEEK     = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [VAL_W-1:0] item_value;
	} in_item_t;

	typedef struct packed {
		logic [VAL_W-1:0] out_value;
		status_t          status;
		logic [OCC_W-1:0] occupancy;
	} out_item_t;

endpackage

FILE: src/rqfi_chan_if.sv
// ----------------------------------------------------------------------------
// rqfi_chan_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface rqfi_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: src/ring_queue_with_front_insert.sv
// result: a result beat is valid in the cycle after its command beat is accepted
// throughput: one command per cycle while results are taken; the single result
// register holds off new commands only while its beat is stalled
// reset: queue empty, head at slot 0, tail at the last slot, no result pending
// ----------------------------------------------------------------------------
// ring_queue_with_front_insert
// circular queue with tail append, head insert, remove and peek commands;
// slot storage is a memory with a registered read port at the head slot
// ----------------------------------------------------------------------------
module ring_queue_with_front_insert #(
	parameter int DEPTH      = rqfi_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = rqfi_pkg::VALUE_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	rqfi_chan_if.sink     in_ch,
	rqfi_chan_if.source   out_ch
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	// queue state
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [VALUE_BITS-1:0] mem_q [DEPTH];

	// result stage
	logic                  v_s1;
	logic                  take_s1;
	rqfi_pkg::status_t     status_s1;
	logic [CW-1:0]         occ_s1;
	logic [VALUE_BITS-1:0] rd_s1;

	// next state
	logic [AW-1:0]         head_n, tail_n, wa;
	logic [CW-1:0]         count_n;
	logic                  we, take;
	rqfi_pkg::status_t     status;
	logic                  full, empty, in_fire, out_fire;
	logic [AW-1:0]         head_inc, head_dec, tail_inc;
	logic [VALUE_BITS-1:0] wd;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;
	assign in_ch.ready = !v_s1 || out_ch.ready;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);

	assign head_inc = (head_q == LAST) ? '0 : head_q + AW'(1);
	assign head_dec = (head_q == '0) ? LAST : head_q - AW'(1);
	assign tail_inc = (tail_q == LAST) ? '0 : tail_q + AW'(1);
	assign wd = VALUE_BITS'(in_ch.data.item_value);

	always_comb begin
		head_n  = head_q;
		tail_n  = tail_q;
		count_n = count_q;
		we      = 1'b0;
		wa      = tail_inc;
		take    = 1'b0;
		status  = rqfi_pkg::ST_OK;
		unique case (in_ch.data.cmd)
			rqfi_pkg::CMD_APPEND: begin
				if (full) begin
					status = rqfi_pkg::ST_FULL;
				end else begin
					tail_n  = tail_inc;
					we      = 1'b1;
					count_n = count_q + CW'(1);
				end
			end
			rqfi_pkg::CMD_PRIORITY: begin
				if (full) begin
					status = rqfi_pkg::ST_FULL;
				end else if (empty) begin
					// empty queue: behaves as an append
					tail_n  = tail_inc;
					we      = 1'b1;
					count_n = count_q + CW'(1);
				end else begin
					head_n  = head_dec;
					wa      = head_dec;
					we      = 1'b1;
					count_n = count_q + CW'(1);
				end
			end
			rqfi_pkg::CMD_REMOVE: begin
				if (empty) begin
					status = rqfi_pkg::ST_EMPTY;
				end else begin
					take    = 1'b1;
					count_n = count_q - CW'(1);
					if (count_q == CW'(1)) begin
						head_n = '0;
						tail_n = LAST;
					end else begin
						head_n = head_inc;
					end
				end
			end
			rqfi_pkg::CMD_PEEK: begin
				if (empty) begin
					status = rqfi_pkg::ST_EMPTY;
				end else begin
					take = 1'b1;
				end
			end
			default: begin
				status = rqfi_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= LAST;
			count_q <= '0;
			v_s1    <= 1'b0;
		end else begin
			if (in_fire) begin
				head_q  <= head_n;
				tail_q  <= tail_n;
				count_q <= count_n;
				v_s1    <= 1'b1;
			end else if (out_fire) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// slot memory; a write lands before the next command reads the head
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (we) begin
				mem_q[wa] <= wd;
			end
			rd_s1     <= mem_q[head_q];
			take_s1   <= take;
			status_s1 <= status;
			occ_s1    <= count_n;
		end
	end

	assign out_ch.valid          = v_s1;
	assign out_ch.data.out_value = take_s1 ? rqfi_pkg::VAL_W'(rd_s1) : '0;
	assign out_ch.data.status    = status_s1;
	assign out_ch.data.occupancy = rqfi_pkg::OCC_W'(occ_s1);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("item count beyond depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> (head_q == '0 && tail_q == LAST))
		else $error("pointers not at home position while empty");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && status_s1 == rqfi_pkg::ST_FULL |-> occ_s1 == FULL_CNT)
		else $error("full status with queue not full");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_ch.data.cmd == rqfi_pkg::CMD_REMOVE && count_q != '0
		|=> count_q == $past(count_q) - CW'(1))
		else $error("remove did not drop one item");

	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && status != rqfi_pkg::ST_OK |=> $stable(count_q) && $stable(head_q)
		&& $stable(tail_q))
		else $error("rejected command changed queue state");
`endif

endmodule
